// ----- rtl/atas_pkg.sv -----
// Package for the airtime-aware transmit scheduler.
// Holds mode, packet-kind and register-index codes and the configuration
// and result structs. No dependencies.
package atas_pkg;

    localparam int SLOT_WIDTH = 16;
    localparam int KIND_WIDTH = 3;
    localparam int MODE_WIDTH = 3;
    localparam int RPT_WIDTH  = 8;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int CFG_DATA_WIDTH  = 64;

    // Mode codes; any other code behaves as hybrid
    localparam logic [MODE_WIDTH-1:0] SEL_BEACON  = 3'd0;
    localparam logic [MODE_WIDTH-1:0] SEL_DENSE   = 3'd1;
    localparam logic [MODE_WIDTH-1:0] SEL_MIXED   = 3'd2;
    localparam logic [MODE_WIDTH-1:0] SEL_BURST   = 3'd3;
    localparam logic [MODE_WIDTH-1:0] SEL_MAXRATE = 3'd4;
    localparam logic [MODE_WIDTH-1:0] SEL_SILENT  = 3'd5;

    // Packet kinds
    localparam logic [KIND_WIDTH-1:0] KIND_NONE    = 3'd0;
    localparam logic [KIND_WIDTH-1:0] KIND_BEACON  = 3'd1;
    localparam logic [KIND_WIDTH-1:0] KIND_DENSE   = 3'd2;
    localparam logic [KIND_WIDTH-1:0] KIND_COMPACT = 3'd3;
    localparam logic [KIND_WIDTH-1:0] KIND_EVENT   = 3'd4;
    localparam logic [KIND_WIDTH-1:0] KIND_CURVE   = 3'd5;

    // Register indexes
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_MODE_SELECT       = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_PHASE_RATES       = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_EVENT_PHASE_RATES = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_AIRTIME_MINS_A    = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_AIRTIME_MINS_B    = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DENSE_FLOOR       = 3'd5;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_REPEAT_COUNT      = 3'd6;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_REPEAT_GAP        = 3'd7;

    localparam logic [RPT_WIDTH-1:0] REPEAT_COUNT_RESET = 8'd3;

    // Configuration as seen by the decision logic, slots already masked
    typedef struct packed {
        logic [MODE_WIDTH-1:0]      mode;
        logic [3:0][SLOT_WIDTH-1:0] phase_rates;
        logic [3:0][SLOT_WIDTH-1:0] event_rates;
        logic [SLOT_WIDTH-1:0]      min_beacon;
        logic [SLOT_WIDTH-1:0]      min_dense;
        logic [SLOT_WIDTH-1:0]      min_compact;
        logic [SLOT_WIDTH-1:0]      min_event;
        logic [SLOT_WIDTH-1:0]      min_curve;
        logic [SLOT_WIDTH-1:0]      dense_floor;
        logic [RPT_WIDTH-1:0]       repeat_count;
        logic [SLOT_WIDTH-1:0]      repeat_gap;
    } cfg_t;

    typedef struct packed {
        logic [KIND_WIDTH-1:0] send_kind;
        logic                  pop_event;
        logic [SLOT_WIDTH-1:0] interval_used;
    } result_t;

    function automatic logic [SLOT_WIDTH-1:0] at_least(
        input logic [SLOT_WIDTH-1:0] desired,
        input logic [SLOT_WIDTH-1:0] minimum
    );
        return (desired > minimum) ? desired : minimum;
    endfunction

endpackage

// ----- rtl/airtime_aware_tx_scheduler.sv -----
// Airtime-aware transmit scheduler: one result item per tick item.
// The result passes the input register, then the decision logic into the result
// register. Throughput: one item per cycle while m_ready is high, set by the
// combinational decision path; the result register decouples stalls.
// Reset (aresetn low, synchronous) clears all last-send times and repeats,
// empties both registers and returns configuration to its reset values.
module airtime_aware_tx_scheduler #(
    parameter int TIME_WIDTH     = 32,
    parameter int INTERVAL_WIDTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [atas_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [atas_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic [TIME_WIDTH-1:0]                s_now_ms,
    input  logic                                 s_phase_valid,
    input  logic [2:0]                           s_flight_phase,
    input  logic                                 s_event_pending,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [atas_pkg::KIND_WIDTH-1:0]      m_send_kind,
    output logic                                 m_pop_event,
    output logic [atas_pkg::SLOT_WIDTH-1:0]      m_interval_used
);
    import atas_pkg::*;

    cfg_t    cfg;
    result_t result;

    logic                  in_valid_reg;
    logic [TIME_WIDTH-1:0] in_now_reg;
    logic                  in_phase_valid_reg;
    logic [2:0]            in_phase_reg;
    logic                  in_pending_reg;
    logic                  out_valid_reg, out_valid_next;
    result_t               out_reg;
    logic                  adv;

    // move the held item into the result register when it is free or draining
    assign adv     = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || adv;

    atas_cfg #(
        .INTERVAL_WIDTH(INTERVAL_WIDTH)
    ) u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_wdata(cfg_wdata),
        .cfg      (cfg)
    );

    atas_core #(
        .TIME_WIDTH(TIME_WIDTH)
    ) u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .adv          (adv),
        .cfg          (cfg),
        .now_ms       (in_now_reg),
        .phase_valid  (in_phase_valid_reg),
        .flight_phase (in_phase_reg),
        .event_pending(in_pending_reg),
        .result       (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_now_reg         <= s_now_ms;
            in_phase_valid_reg <= s_phase_valid;
            in_phase_reg       <= s_flight_phase;
            in_pending_reg     <= s_event_pending;
        end
    end

    always_comb begin
        if (adv) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_reg <= result;
        end
    end

    assign m_valid         = out_valid_reg;
    assign m_send_kind     = out_reg.send_kind;
    assign m_pop_event     = out_reg.pop_event;
    assign m_interval_used = out_reg.interval_used;

endmodule

// ----- rtl/atas_cfg.sv -----
// Configuration register file of the transmit scheduler.
// Plain write port; presents the settings as one cfg_t, slots masked.
// Depends on atas_pkg.
module atas_cfg #(
    parameter int INTERVAL_WIDTH = 16
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [atas_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  logic [atas_pkg::CFG_DATA_WIDTH-1:0]  cfg_wdata,
    output atas_pkg::cfg_t                       cfg
);
    import atas_pkg::*;

    localparam int SLOT_BITS = (INTERVAL_WIDTH < SLOT_WIDTH) ? INTERVAL_WIDTH : SLOT_WIDTH;
    localparam logic [SLOT_WIDTH:0] SLOT_ONE = 1;
    localparam logic [SLOT_WIDTH-1:0] SLOT_MASK =
        SLOT_WIDTH'((SLOT_ONE << SLOT_BITS) - SLOT_ONE);

    logic [MODE_WIDTH-1:0]      mode_reg;
    logic [63:0]                phase_rates_reg;
    logic [63:0]                event_rates_reg;
    logic [47:0]                mins_a_reg;
    logic [31:0]                mins_b_reg;
    logic [SLOT_WIDTH-1:0]      dense_floor_reg;
    logic [RPT_WIDTH-1:0]       repeat_count_reg;
    logic [SLOT_WIDTH-1:0]      repeat_gap_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg         <= SEL_SILENT;
            phase_rates_reg  <= '0;
            event_rates_reg  <= '0;
            mins_a_reg       <= '0;
            mins_b_reg       <= '0;
            dense_floor_reg  <= '0;
            repeat_count_reg <= REPEAT_COUNT_RESET;
            repeat_gap_reg   <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_MODE_SELECT:       mode_reg         <= cfg_wdata[MODE_WIDTH-1:0];
                REG_PHASE_RATES:       phase_rates_reg  <= cfg_wdata;
                REG_EVENT_PHASE_RATES: event_rates_reg  <= cfg_wdata;
                REG_AIRTIME_MINS_A:    mins_a_reg       <= cfg_wdata[47:0];
                REG_AIRTIME_MINS_B:    mins_b_reg       <= cfg_wdata[31:0];
                REG_DENSE_FLOOR:       dense_floor_reg  <= cfg_wdata[SLOT_WIDTH-1:0];
                REG_REPEAT_COUNT:      repeat_count_reg <= cfg_wdata[RPT_WIDTH-1:0];
                REG_REPEAT_GAP:        repeat_gap_reg   <= cfg_wdata[SLOT_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        cfg.mode = mode_reg;
        for (int k = 0; k < 4; k++) begin
            cfg.phase_rates[k] = phase_rates_reg[k*SLOT_WIDTH +: SLOT_WIDTH] & SLOT_MASK;
            cfg.event_rates[k] = event_rates_reg[k*SLOT_WIDTH +: SLOT_WIDTH] & SLOT_MASK;
        end
        cfg.min_beacon   = mins_a_reg[15:0]  & SLOT_MASK;
        cfg.min_dense    = mins_a_reg[31:16] & SLOT_MASK;
        cfg.min_compact  = mins_a_reg[47:32] & SLOT_MASK;
        cfg.min_event    = mins_b_reg[15:0]  & SLOT_MASK;
        cfg.min_curve    = mins_b_reg[31:16] & SLOT_MASK;
        cfg.dense_floor  = dense_floor_reg & SLOT_MASK;
        cfg.repeat_count = repeat_count_reg;
        cfg.repeat_gap   = repeat_gap_reg & SLOT_MASK;
    end

endmodule

// ----- rtl/atas_core.sv -----
// Decision logic and scheduler state: last-send times and burst repeats.
// State advances once per item when adv is high. Depends on atas_pkg.
module atas_core #(
    parameter int TIME_WIDTH = 32
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            adv,
    input  atas_pkg::cfg_t                  cfg,
    input  logic [TIME_WIDTH-1:0]           now_ms,
    input  logic                            phase_valid,
    input  logic [2:0]                      flight_phase,
    input  logic                            event_pending,
    output atas_pkg::result_t               result
);
    import atas_pkg::*;

    logic [TIME_WIDTH-1:0] last_beacon_reg, last_beacon_next;
    logic [TIME_WIDTH-1:0] last_dense_reg,  last_dense_next;
    logic [TIME_WIDTH-1:0] last_curve_reg,  last_curve_next;
    logic [TIME_WIDTH-1:0] last_event_reg,  last_event_next;
    logic [RPT_WIDTH-1:0]  repeats_reg,     repeats_next;

    logic [1:0]            slot;
    logic [SLOT_WIDTH-1:0] rate, erate;
    logic [SLOT_WIDTH-1:0] ivl_b, ivl_d, ivl_c, gap, dgap;
    logic [TIME_WIDTH-1:0] el_b, el_d, el_c, el_e, to_next;

    // Pad slot unless the phase is valid and known
    assign slot  = (phase_valid && flight_phase <= 3'd3) ? flight_phase[1:0] : 2'd0;
    assign rate  = cfg.phase_rates[slot];
    assign erate = cfg.event_rates[slot];

    assign ivl_b = at_least(rate, cfg.min_beacon);
    assign ivl_d = at_least(rate, cfg.min_dense);
    assign ivl_c = at_least(erate, cfg.min_compact);
    assign gap   = at_least(cfg.repeat_gap, cfg.min_event);
    assign dgap  = at_least(cfg.dense_floor, cfg.min_dense);

    assign el_b    = now_ms - last_beacon_reg;
    assign el_d    = now_ms - last_dense_reg;
    assign el_c    = now_ms - last_curve_reg;
    assign el_e    = now_ms - last_event_reg;
    assign to_next = last_beacon_reg + TIME_WIDTH'(ivl_b) - now_ms;

    always_comb begin
        last_beacon_next     = last_beacon_reg;
        last_dense_next      = last_dense_reg;
        last_curve_next      = last_curve_reg;
        last_event_next      = last_event_reg;
        repeats_next         = repeats_reg;
        result.send_kind     = KIND_NONE;
        result.pop_event     = 1'b0;
        result.interval_used = '0;
        case (cfg.mode)
            SEL_BEACON: begin
                result.interval_used = ivl_b;
                if (el_b >= TIME_WIDTH'(ivl_b)) begin
                    result.send_kind = KIND_BEACON;
                    last_beacon_next = now_ms;
                end
            end
            SEL_DENSE: begin
                result.interval_used = ivl_d;
                if (el_d >= TIME_WIDTH'(ivl_d)) begin
                    result.send_kind = KIND_DENSE;
                    last_dense_next  = now_ms;
                end
            end
            SEL_BURST: begin
                result.interval_used = ivl_c;
                if (repeats_reg != '0) begin
                    if (el_e >= TIME_WIDTH'(gap)) begin
                        if (event_pending) begin
                            result.send_kind = KIND_EVENT;
                            last_event_next  = now_ms;
                            repeats_next     = repeats_reg - RPT_WIDTH'(1);
                            // last repeat: pop the event and restart the beacon timer
                            if (repeats_reg == RPT_WIDTH'(1)) begin
                                result.pop_event = 1'b1;
                                last_beacon_next = now_ms;
                            end
                        end else begin
                            // event vanished mid-burst: drop the burst
                            repeats_next = '0;
                        end
                    end
                end else if (event_pending) begin
                    repeats_next    = cfg.repeat_count;
                    last_event_next = '0;
                end else if (el_b >= TIME_WIDTH'(ivl_c)) begin
                    result.send_kind = KIND_COMPACT;
                    last_beacon_next = now_ms;
                end
            end
            SEL_MAXRATE: begin
                result.interval_used = cfg.min_curve;
                if (el_c >= TIME_WIDTH'(cfg.min_curve)) begin
                    result.send_kind = KIND_CURVE;
                    last_curve_next  = now_ms;
                end
            end
            SEL_SILENT: ;
            default: begin
                // hybrid; a beacon also restarts the dense timer
                result.interval_used = ivl_b;
                if (el_b >= TIME_WIDTH'(ivl_b)) begin
                    result.send_kind = KIND_BEACON;
                    last_beacon_next = now_ms;
                    last_dense_next  = now_ms;
                end else if (el_d >= TIME_WIDTH'(dgap) &&
                             to_next > TIME_WIDTH'(cfg.min_dense)) begin
                    result.send_kind = KIND_DENSE;
                    last_dense_next  = now_ms;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            last_beacon_reg <= '0;
            last_dense_reg  <= '0;
            last_curve_reg  <= '0;
            last_event_reg  <= '0;
            repeats_reg     <= '0;
        end else if (adv) begin
            last_beacon_reg <= last_beacon_next;
            last_dense_reg  <= last_dense_next;
            last_curve_reg  <= last_curve_next;
            last_event_reg  <= last_event_next;
            repeats_reg     <= repeats_next;
        end
    end

endmodule

// ----- rtl/atas_checker.sv -----
// Port-level checks for the transmit scheduler, bound to the top level.
// Depends on atas_pkg.
module atas_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_valid,
    input logic                            s_ready,
    input logic                            m_valid,
    input logic                            m_ready,
    input logic [atas_pkg::KIND_WIDTH-1:0] m_send_kind,
    input logic                            m_pop_event,
    input logic [atas_pkg::SLOT_WIDTH-1:0] m_interval_used
);
    import atas_pkg::*;

    // an accepted item must find m_valid high once it has passed the input and result registers
    a_accept_to_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |-> ##2 m_valid)
        else $error("accepted item did not produce a result in time");

    // an empty result register never blocks the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty result register");

    // a pop only goes with the last event repeat
    a_pop_with_event: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_pop_event) |-> (m_send_kind == KIND_EVENT))
        else $error("pop_event without an event packet");

    a_result_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_send_kind) &&
                                   $stable(m_pop_event) && $stable(m_interval_used)))
        else $error("stalled result changed");

endmodule

bind airtime_aware_tx_scheduler atas_checker u_atas_checker (
    .aclk           (aclk),
    .aresetn        (aresetn),
    .s_valid        (s_valid),
    .s_ready        (s_ready),
    .m_valid        (m_valid),
    .m_ready        (m_ready),
    .m_send_kind    (m_send_kind),
    .m_pop_event    (m_pop_event),
    .m_interval_used(m_interval_used)
);
